FILE: src/prlm_pkg.sv
// ----------------------------------------------------------------------------
// prlm_pkg
// Shared constants, types and codes for the pending request latency monitor.
// ----------------------------------------------------------------------------
package prlm_pkg;

  localparam int ENTRIES = 16;
  localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int PEND_W  = $clog2(ENTRIES + 1);
  localparam int CLS_W   = 4;

  localparam logic FUNC_START  = 1'b0;
  localparam logic FUNC_FINISH = 1'b1;

  typedef enum logic [2:0] {
    ST_INSERTED    = 3'd0,
    ST_REFRESHED   = 3'd1,
    ST_RELEASED    = 3'd2,
    ST_NOT_FOUND   = 3'd3,
    ST_TABLE_FULL  = 3'd4,
    ST_WRONG_CLASS = 3'd5
  } status_t;

  typedef struct packed {
    logic [CLS_W-1:0] cls;
    logic [31:0]      key;
    logic [31:0]      pos;
    logic [31:0]      start;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef struct packed {
    logic        inc;
    logic        dec;
    logic        add;
    logic [31:0] delay;
  } stats_upd_t;

endpackage

FILE: src/prlm_ifs.sv
// ----------------------------------------------------------------------------
// prlm request and result channels
// Valid/ready channels carrying one request item and one result item.
// ----------------------------------------------------------------------------
interface prlm_req_if;
  logic                        valid;
  logic                        ready;
  logic                        func;
  logic [prlm_pkg::CLS_W-1:0]  req_class;
  logic [31:0]                 req_key;
  logic [31:0]                 req_pos;
  logic [31:0]                 now;

  modport source (output valid, func, req_class, req_key, req_pos, now, input ready);
  modport sink   (input valid, func, req_class, req_key, req_pos, now, output ready);
endinterface

interface prlm_rsp_if;
  logic                valid;
  logic                ready;
  prlm_pkg::status_t   status;
  logic [4:0]          pending_count;
  logic [31:0]         completed_count;
  logic [63:0]         total_delay;
  logic signed [31:0]  this_delay;

  modport source (output valid, status, pending_count, completed_count, total_delay,
                  this_delay, input ready);
  modport sink   (input valid, status, pending_count, completed_count, total_delay,
                  this_delay, output ready);
endinterface

FILE: src/prlm_entry_ram.sv
// ----------------------------------------------------------------------------
// prlm_entry_ram
// Simple dual-port RAM, one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module prlm_entry_ram #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 8,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: src/prlm_stats.sv
// ----------------------------------------------------------------------------
// prlm_stats
// Pending count, completion count and delay accumulator.
// ----------------------------------------------------------------------------
module prlm_stats (
  input  logic                        clk,
  input  logic                        rst,
  input  prlm_pkg::stats_upd_t        upd,
  output logic [prlm_pkg::PEND_W-1:0] pending,
  output logic [31:0]                 done,
  output logic [63:0]                 delay_sum
);

  always_ff @(posedge clk) begin
    if (rst) begin
      pending   <= '0;
      done      <= '0;
      delay_sum <= '0;
    end else begin
      if (upd.inc) begin
        pending <= pending + prlm_pkg::PEND_W'(1);
      end else if (upd.dec && pending != '0) begin
        pending <= pending - prlm_pkg::PEND_W'(1);
      end
      if (upd.add) begin
        done      <= done + 32'd1;
        delay_sum <= delay_sum + {32'd0, upd.delay};
      end
    end
  end

endmodule

FILE: src/pending_request_latency_monitor_unit.sv
// ----------------------------------------------------------------------------
// pending_request_latency_monitor_unit
// Sequence: a tracked class scans the table (one RAM read per entry, the scan stops at
// the first match or the last entry), then S_CALC, S_UPD, S_RESP; a wrong class goes to S_RESP.
// One request at a time: the next can be accepted in the cycle after the result is
// loaded, and S_RESP waits while the result side stalls.
// Reset (rst, synchronous): valid bits, counters and tracked_class cleared; RAM undefined.
// ----------------------------------------------------------------------------
module pending_request_latency_monitor_unit (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_we,
  input  logic [prlm_pkg::CLS_W-1:0] cfg_wdata,
  prlm_req_if.sink                   req,
  prlm_rsp_if.source                 rsp
);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_SCAN = 5'b00010,
    S_CALC = 5'b00100,
    S_UPD  = 5'b01000,
    S_RESP = 5'b10000
  } state_t;

  state_t state;

  logic [prlm_pkg::CLS_W-1:0] tracked_class;
  logic [prlm_pkg::ENTRIES-1:0] valid_bits;

  // latched request
  logic                       op;
  logic [prlm_pkg::CLS_W-1:0] cls;
  logic [31:0]                key;
  logic [31:0]                pos;
  logic [31:0]                now_r;

  logic [prlm_pkg::IDX_W:0]   rd_cnt;
  logic                       chk_vld;
  logic [prlm_pkg::IDX_W-1:0] chk_idx;
  logic                       hit;
  logic [prlm_pkg::IDX_W-1:0] hit_idx;
  logic [31:0]                hit_start;
  logic [31:0]                delay;
  prlm_pkg::status_t          status_r;

  logic                       rd_en;
  logic [prlm_pkg::IDX_W-1:0] rd_addr;
  prlm_pkg::entry_t           rd_entry;
  logic [prlm_pkg::ENTRY_W-1:0] rd_data;
  logic                       wr_en;
  logic [prlm_pkg::IDX_W-1:0] wr_addr;
  prlm_pkg::entry_t           wr_entry;

  logic                       match;
  logic                       last_chk;
  logic                       free_any;
  logic [prlm_pkg::IDX_W-1:0] free_idx;
  logic [31:0]                delay_next;
  logic                       out_free;

  prlm_pkg::stats_upd_t              upd;
  logic [prlm_pkg::PEND_W-1:0]       pending;
  logic [31:0]                       done;
  logic [63:0]                       delay_sum;

  assign rd_en   = (state == S_SCAN) && (rd_cnt < (prlm_pkg::IDX_W + 1)'(prlm_pkg::ENTRIES));
  assign rd_addr = rd_cnt[prlm_pkg::IDX_W-1:0];
  assign rd_entry = prlm_pkg::entry_t'(rd_data);

  assign match = chk_vld && valid_bits[chk_idx] && rd_entry.cls == cls &&
                 rd_entry.key == key && rd_entry.pos == pos;
  assign last_chk = chk_vld && chk_idx == prlm_pkg::IDX_W'(prlm_pkg::ENTRIES - 1);

  // lowest free slot
  always_comb begin
    free_any = 1'b0;
    free_idx = '0;
    for (int i = prlm_pkg::ENTRIES - 1; i >= 0; i--) begin
      if (!valid_bits[i]) begin
        free_any = 1'b1;
        free_idx = prlm_pkg::IDX_W'(i);
      end
    end
  end

  assign delay_next = now_r - hit_start;

  assign wr_en    = (state == S_CALC) && (op == prlm_pkg::FUNC_START) && (hit || free_any);
  assign wr_addr  = hit ? hit_idx : free_idx;
  assign wr_entry = '{cls: cls, key: key, pos: pos, start: now_r};

  prlm_entry_ram #(
    .DEPTH (prlm_pkg::ENTRIES),
    .WIDTH (prlm_pkg::ENTRY_W),
    .AW    (prlm_pkg::IDX_W)
  ) u_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (wr_entry),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  always_comb begin
    upd       = '0;
    upd.delay = delay;
    if (state == S_UPD) begin
      upd.inc = (status_r == prlm_pkg::ST_INSERTED);
      upd.dec = (status_r == prlm_pkg::ST_RELEASED);
      upd.add = (status_r == prlm_pkg::ST_RELEASED) && delay != 32'd0 && !delay[31];
    end
  end

  prlm_stats u_stats (
    .clk       (clk),
    .rst       (rst),
    .upd       (upd),
    .pending   (pending),
    .done      (done),
    .delay_sum (delay_sum)
  );

  assign req.ready = (state == S_IDLE) && !rst;
  assign out_free  = !rsp.valid || rsp.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      tracked_class <= '0;
    end else if (cfg_we) begin
      tracked_class <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      valid_bits <= '0;
      chk_vld    <= 1'b0;
      rsp.valid  <= 1'b0;
    end else begin
      chk_vld <= rd_en;
      if (state == S_RESP && out_free) begin
        rsp.valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp.valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (req.valid) begin
            state <= (req.req_class == tracked_class) ? S_SCAN : S_RESP;
          end
        end
        S_SCAN: begin
          if (match || last_chk) begin
            state <= S_CALC;
          end
        end
        S_CALC: begin
          if (op == prlm_pkg::FUNC_START) begin
            if (!hit && free_any) begin
              valid_bits[free_idx] <= 1'b1;
            end
          end else if (hit) begin
            valid_bits[hit_idx] <= 1'b0;
          end
          state <= S_UPD;
        end
        S_UPD: begin
          state <= S_RESP;
        end
        S_RESP: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        if (req.valid) begin
          op       <= req.func;
          cls      <= req.req_class;
          key      <= req.req_key;
          pos      <= req.req_pos;
          now_r    <= req.now;
          rd_cnt   <= '0;
          hit      <= 1'b0;
          delay    <= '0;
          status_r <= prlm_pkg::ST_WRONG_CLASS;
        end
      end
      S_SCAN: begin
        if (rd_en) begin
          rd_cnt <= rd_cnt + (prlm_pkg::IDX_W + 1)'(1);
        end
        if (rd_en) begin
          chk_idx <= rd_addr;
        end
        if (match) begin
          hit       <= 1'b1;
          hit_idx   <= chk_idx;
          hit_start <= rd_entry.start;
        end
      end
      S_CALC: begin
        if (op == prlm_pkg::FUNC_START) begin
          if (hit) begin
            status_r <= prlm_pkg::ST_REFRESHED;
          end else if (free_any) begin
            status_r <= prlm_pkg::ST_INSERTED;
          end else begin
            status_r <= prlm_pkg::ST_TABLE_FULL;
          end
        end else if (hit) begin
          status_r <= prlm_pkg::ST_RELEASED;
          delay    <= delay_next;
        end else begin
          status_r <= prlm_pkg::ST_NOT_FOUND;
        end
      end
      S_UPD: begin
      end
      S_RESP: begin
        if (out_free) begin
          rsp.status          <= status_r;
          rsp.pending_count   <= 5'(pending);
          rsp.completed_count <= done;
          rsp.total_delay     <= delay_sum;
          rsp.this_delay      <= delay;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

FILE: tb/sv/tb.sv
// ----------------------------------------------------------------------------
// tb - pending request latency monitor testbench
// Drives request items through the valid/ready request channel and checks
// every result against an in-bench model of the pending request table and its
// latency counters. Covers a directed pass, a change of the tracked class,
// three random phases with different idle patterns and a long result stall.
// ----------------------------------------------------------------------------
module tb;
  import prlm_pkg::*;

  localparam int POOL_SIZE   = 24;
  localparam int DRAIN_WAIT  = 30;
  localparam int HOLD_CYCLES = 400;
  localparam int ITEMS_PHASE = 600;

  typedef struct {
    logic             func;
    logic [CLS_W-1:0] cls;
    logic [31:0]      key;
    logic [31:0]      pos;
    logic [31:0]      now;
  } req_item_t;

  typedef struct {
    status_t            status;
    logic [4:0]         pending;
    logic [31:0]        completed;
    logic [63:0]        total;
    logic signed [31:0] delay;
  } latency_rsp_t;

  logic             clk;
  logic             rst;
  logic             cfg_we;
  logic [CLS_W-1:0] cfg_wdata;

  prlm_req_if req_ch ();
  prlm_rsp_if rsp_ch ();

  pending_request_latency_monitor_unit dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .req       (req_ch),
    .rsp       (rsp_ch)
  );

  // model of the table and counters
  logic [CLS_W-1:0] mon_class = '0;
  bit               tbl_valid [ENTRIES];
  logic [CLS_W-1:0] tbl_cls   [ENTRIES];
  logic [31:0]      tbl_key   [ENTRIES];
  logic [31:0]      tbl_pos   [ENTRIES];
  logic [31:0]      tbl_start [ENTRIES];
  logic [4:0]       pend_cnt  = '0;
  logic [31:0]      done_cnt  = '0;
  logic [63:0]      delay_acc = '0;

  latency_rsp_t latency_results_q [$];
  int           err_cnt = 0;

  int          req_idle_pct = 34;
  int          rsp_idle_pct = 55;
  bit          hold_request = 1'b0;
  logic [31:0] tick_now = 32'd1000;
  logic [31:0] pool_key [POOL_SIZE];
  logic [31:0] pool_pos [POOL_SIZE];

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  function automatic latency_rsp_t predict_monitor_result(req_item_t r);
    latency_rsp_t o;
    int           hit;
    int           slot;
    int           i;
    logic [31:0]  d;
    d    = '0;
    hit  = -1;
    slot = -1;
    for (i = ENTRIES - 1; i >= 0; i--) begin
      if (tbl_valid[i] && tbl_cls[i] == r.cls && tbl_key[i] == r.key && tbl_pos[i] == r.pos)
        hit = i;
      if (!tbl_valid[i])
        slot = i;
    end
    if (r.cls != mon_class) begin
      o.status = ST_WRONG_CLASS;
    end else if (r.func == FUNC_START) begin
      if (hit >= 0) begin
        tbl_start[hit] = r.now;
        o.status = ST_REFRESHED;
      end else if (slot < 0) begin
        o.status = ST_TABLE_FULL;
      end else begin
        tbl_valid[slot] = 1'b1;
        tbl_cls[slot]   = r.cls;
        tbl_key[slot]   = r.key;
        tbl_pos[slot]   = r.pos;
        tbl_start[slot] = r.now;
        pend_cnt++;
        o.status = ST_INSERTED;
      end
    end else begin
      if (hit < 0) begin
        o.status = ST_NOT_FOUND;
      end else begin
        d = r.now - tbl_start[hit];
        // only a strictly positive signed delay is counted
        if (d != 0 && !d[31]) begin
          done_cnt++;
          delay_acc += {32'd0, d};
        end
        tbl_valid[hit] = 1'b0;
        if (pend_cnt > 0)
          pend_cnt--;
        o.status = ST_RELEASED;
      end
    end
    o.pending   = pend_cnt;
    o.completed = done_cnt;
    o.total     = delay_acc;
    o.delay     = d;
    return o;
  endfunction

  function automatic req_item_t mk_req(logic f, logic [CLS_W-1:0] c, logic [31:0] k,
                                       logic [31:0] p, logic [31:0] t);
    req_item_t r;
    r.func = f;
    r.cls  = c;
    r.key  = k;
    r.pos  = p;
    r.now  = t;
    return r;
  endfunction

  function automatic req_item_t random_req(int start_pct);
    req_item_t r;
    int        idx;
    int        sel;
    sel = $urandom_range(99);
    if (sel < 5)
      tick_now = $urandom;
    else if (sel >= 8)
      tick_now += 32'($urandom_range(1, 60));
    r.now  = tick_now;
    r.cls  = ($urandom_range(99) < 8) ? CLS_W'($urandom_range(15)) : mon_class;
    r.func = ($urandom_range(99) < start_pct) ? FUNC_START : FUNC_FINISH;
    if (r.func == FUNC_FINISH && $urandom_range(99) < 10) begin
      // unknown key, never inserted so the table does not leak
      r.key = $urandom;
      r.pos = $urandom;
    end else begin
      idx   = $urandom_range(POOL_SIZE - 1);
      r.key = pool_key[idx];
      r.pos = pool_pos[idx];
    end
    return r;
  endfunction

  // offer one request, wait for the handshake, then record its prediction
  task automatic send_req(req_item_t r);
    if ($urandom_range(99) < req_idle_pct) begin
      req_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    req_ch.valid     <= 1'b1;
    req_ch.func      <= r.func;
    req_ch.req_class <= r.cls;
    req_ch.req_key   <= r.key;
    req_ch.req_pos   <= r.pos;
    req_ch.now       <= r.now;
    do @(posedge clk); while (!req_ch.ready);
    latency_results_q.push_back(predict_monitor_result(r));
  endtask

  task automatic drain_results();
    req_ch.valid <= 1'b0;
    while (latency_results_q.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  task automatic write_class(logic [CLS_W-1:0] v);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    mon_class = v;
    cfg_we    <= 1'b0;
  endtask

  // free every entry of the current class before the class changes
  task automatic release_pending();
    int i;
    for (i = 0; i < ENTRIES; i++)
      if (tbl_valid[i] && tbl_cls[i] == mon_class)
        send_req(mk_req(FUNC_FINISH, mon_class, tbl_key[i], tbl_pos[i], tick_now));
  endtask

  task automatic test_directed();
    int i;
    write_class(4'd0);
    send_req(mk_req(FUNC_START, 4'd0, 32'h0, 32'h0, 32'h0));
    send_req(mk_req(FUNC_START, 4'd0, '1, '1, '1));
    send_req(mk_req(FUNC_START, 4'd0, 32'h0, 32'h0, 32'd5));
    send_req(mk_req(FUNC_FINISH, 4'd0, 32'h0, 32'h0, 32'd5));           // zero delay
    send_req(mk_req(FUNC_FINISH, 4'd0, 32'h0, 32'h0, 32'd9));           // no match
    send_req(mk_req(FUNC_FINISH, 4'd0, '1, '1, 32'h7FFF_FFFE));         // largest positive
    send_req(mk_req(FUNC_START, 4'd15, 32'd1, 32'd2, 32'd3));
    send_req(mk_req(FUNC_FINISH, 4'd15, 32'd1, 32'd2, 32'd3));
    send_req(mk_req(FUNC_START, 4'd0, 32'd1, 32'd2, 32'd100));
    send_req(mk_req(FUNC_FINISH, 4'd0, 32'd1, 32'd2, 32'd50));          // negative
    send_req(mk_req(FUNC_START, 4'd0, 32'd3, 32'd4, 32'd0));
    send_req(mk_req(FUNC_FINISH, 4'd0, 32'd3, 32'd4, 32'h8000_0000));   // most negative
    send_req(mk_req(FUNC_START, 4'd0, 32'd5, 32'd6, 32'd10));
    send_req(mk_req(FUNC_FINISH, 4'd0, 32'd5, 32'd6, 32'd20));
    for (i = 0; i < ENTRIES; i++)
      send_req(mk_req(FUNC_START, 4'd0, pool_key[i], pool_pos[i], 32'(i)));
    send_req(mk_req(FUNC_START, 4'd0, pool_key[ENTRIES], pool_pos[ENTRIES], 32'd40));
    send_req(mk_req(FUNC_START, 4'd0, pool_key[3], pool_pos[3], 32'd77));
    send_req(mk_req(FUNC_FINISH, 4'd0, pool_key[ENTRIES], pool_pos[ENTRIES], 32'd80));
    drain_results();
  endtask

  // entries keep the class they were inserted with
  task automatic test_class_switch();
    write_class(4'd9);
    send_req(mk_req(FUNC_FINISH, 4'd9, pool_key[0], pool_pos[0], 32'd90));
    send_req(mk_req(FUNC_START, 4'd9, pool_key[0], pool_pos[0], 32'd91));
    send_req(mk_req(FUNC_START, 4'd0, pool_key[1], pool_pos[1], 32'd92));
    drain_results();
    release_pending();
    drain_results();
    write_class(4'd0);
    send_req(mk_req(FUNC_FINISH, 4'd0, pool_key[0], pool_pos[0], 32'd500));
    drain_results();
  endtask

  task automatic test_random(logic [CLS_W-1:0] cls, int n, int start_pct,
                             int snd_idle, int rcv_idle);
    int i;
    release_pending();
    drain_results();
    write_class(cls);
    req_idle_pct = snd_idle;
    rsp_idle_pct = rcv_idle;
    for (i = 0; i < n; i++)
      send_req(random_req(start_pct));
    drain_results();
  endtask

  task automatic test_backpressure();
    int i;
    req_idle_pct = 0;
    rsp_idle_pct = 0;
    hold_request = 1'b1;
    for (i = 0; i < 50; i++)
      send_req(random_req(60));
    drain_results();
    hold_request = 1'b0;
  endtask

  // result side ready, with one long hold-off on request
  initial begin
    int held;
    held = 0;
    rsp_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request && held < HOLD_CYCLES) begin
        rsp_ch.ready <= 1'b0;
        held++;
      end else begin
        rsp_ch.ready <= ($urandom_range(99) >= rsp_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    latency_rsp_t e;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      if (latency_results_q.size() == 0) begin
        $error("result with no request pending: status %0d", rsp_ch.status);
        err_cnt++;
      end else begin
        e = latency_results_q.pop_front();
        if (rsp_ch.status !== e.status) begin
          $error("status: expected %0d, actual %0d", e.status, rsp_ch.status);
          err_cnt++;
        end
        if (rsp_ch.pending_count !== e.pending) begin
          $error("pending_count: expected %0d, actual %0d", e.pending, rsp_ch.pending_count);
          err_cnt++;
        end
        if (rsp_ch.completed_count !== e.completed) begin
          $error("completed_count: expected %0d, actual %0d", e.completed,
                 rsp_ch.completed_count);
          err_cnt++;
        end
        if (rsp_ch.total_delay !== e.total) begin
          $error("total_delay: expected %0d, actual %0d", e.total, rsp_ch.total_delay);
          err_cnt++;
        end
        if (rsp_ch.this_delay !== e.delay) begin
          $error("this_delay: expected %0d, actual %0d", e.delay, rsp_ch.this_delay);
          err_cnt++;
        end
      end
    end
  end

  initial begin
    int i;
    rst              <= 1'b1;
    cfg_we           <= 1'b0;
    cfg_wdata        <= '0;
    req_ch.valid     <= 1'b0;
    req_ch.func      <= FUNC_START;
    req_ch.req_class <= '0;
    req_ch.req_key   <= '0;
    req_ch.req_pos   <= '0;
    req_ch.now       <= '0;
    for (i = 0; i < ENTRIES; i++)
      tbl_valid[i] = 1'b0;
    for (i = 0; i < POOL_SIZE; i++) begin
      pool_key[i] = $urandom;
      pool_pos[i] = $urandom;
    end
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed();
    test_class_switch();
    test_random(4'd0, ITEMS_PHASE, 50, 34, 55);
    test_random(4'd15, ITEMS_PHASE, 65, 55, 34);
    test_random(CLS_W'($urandom_range(1, 14)), ITEMS_PHASE, 58, 0, 0);
    test_backpressure();

    if (err_cnt == 0 && latency_results_q.size() == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule
